// ----- rtl/core/olist_pkg.sv -----
// Shared types and constants for the ordered list engine.
// Used by olist_cell and ordered_list_engine_unit; no dependencies.
package olist_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;

    typedef enum logic [2:0] {
        FN_ADD_FRONT = 3'd0,
        FN_ADD_BACK  = 3'd1,
        FN_ADD_AFTER = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_INDEX = 3'd5,
        FN_SWAP      = 3'd6,
        FN_DUMP      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE,
        CELL_SWAP
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t                 op;
        logic [CNT_W-1:0]         pos;      // insert/delete position, first swap position
        logic [CNT_W-1:0]         pos_b;    // second swap position
        logic [CNT_W-1:0]         count;    // live length, for rotate wrap
        logic [CNT_W-1:0]         rd_pos;   // cell driving the read bus
        logic signed [VAL_W-1:0]  ins_val;
        logic signed [VAL_W-1:0]  a_val;
        logic signed [VAL_W-1:0]  b_val;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ordered_list_engine_unit.sv -----
// Ordered list engine top level: request decode, sequencer and result register
// around a row of olist_cell. Depends on olist_pkg and olist_cell.
//
// Holds up to CAPACITY signed 32-bit words in a row of cells, position 0 in the
// first cell. Add, delete and their error cases register their result as the
// request is taken, the row shifting in that same cycle. A swap goes through
// S_SWAP, as the single read bus across the row fetches the first word, then
// the second. A dump gives one word per cycle while the output is free, count
// words (one if the list is empty): the live part of the row rotates one
// step per word, the head cell giving the result, so after count steps the
// order is back as it was. A new request is taken only once the previous one's
// last result has left the result register or leaves it in the same cycle.
// No clearing pass after reset: only positions below the count are ever read.
module ordered_list_engine_unit #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [2:0]                         func,
    input  logic signed [olist_pkg::VAL_W-1:0] item_value,
    input  logic [olist_pkg::POS_W-1:0]        position_a,
    input  logic [olist_pkg::POS_W-1:0]        position_b,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [olist_pkg::VAL_W-1:0] out_value,
    output logic [1:0]                         status,
    output logic [olist_pkg::CNT_W-1:0]        element_count,
    output logic                               last
);
    import olist_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWAP,
        S_DUMP
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        pa_reg;
    logic [CNT_W-1:0]        pb_reg;
    logic signed [VAL_W-1:0] a_val_reg;
    logic [CNT_W-1:0]        dump_idx_reg;
    logic                    rsp_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    status_t                 status_reg;
    logic [CNT_W-1:0]        count_out_reg;
    logic                    last_reg;

    cell_ctrl_t              ctrl;
    status_t                 op_status;
    logic                    start_swap;
    logic                    start_dump;
    logic                    out_free;
    logic                    acc;
    logic                    rsp_load;
    logic [CNT_W-1:0]        pa_w;
    logic [CNT_W-1:0]        pb_w;
    logic signed [VAL_W-1:0] bus_val;
    logic                    dump_last;

    logic signed [VAL_W-1:0] cell_val [CAPACITY];
    logic signed [VAL_W-1:0] cell_rd  [CAPACITY];

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign acc       = req_valid && req_ready;
    assign pa_w      = {1'b0, position_a};
    assign pb_w      = {1'b0, position_b};
    assign dump_last = (dump_idx_reg == count_reg - CNT_W'(1));

    // result register takes a new word this cycle
    assign rsp_load  = (acc && !start_swap && !start_dump)
                    || (((state_reg == S_SWAP) || (state_reg == S_DUMP)) && out_free);

    // one-hot read bus across the row
    always_comb
    begin
        bus_val = '0;
        for (int i = 0; i < CAPACITY; i++)
            bus_val = bus_val | cell_rd[i];
    end

    always_comb
    begin
        ctrl         = '0;
        ctrl.op      = CELL_HOLD;
        ctrl.count   = count_reg;
        ctrl.ins_val = item_value;
        op_status    = ST_OK;
        cnt_next     = count_reg;
        start_swap   = 1'b0;
        start_dump   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (func_t'(func))
                        FN_ADD_FRONT, FN_ADD_BACK, FN_ADD_AFTER:
                        begin
                            if (count_reg >= CAP_C)
                                op_status = ST_FULL;
                            else if (func_t'(func) == FN_ADD_AFTER && pa_w >= count_reg)
                                op_status = ST_RANGE;
                            else
                            begin
                                ctrl.op  = CELL_INSERT;
                                cnt_next = count_reg + CNT_W'(1);
                                if (func_t'(func) == FN_ADD_BACK)
                                    ctrl.pos = count_reg;
                                else if (func_t'(func) == FN_ADD_AFTER && pa_w != '0)
                                    ctrl.pos = pa_w + CNT_W'(1);
                                else
                                    ctrl.pos = '0;
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_INDEX:
                        begin
                            if (count_reg == '0)
                                op_status = ST_EMPTY;
                            else if (func_t'(func) == FN_DEL_INDEX && pa_w >= count_reg)
                                op_status = ST_RANGE;
                            else
                            begin
                                ctrl.op  = CELL_DELETE;
                                cnt_next = count_reg - CNT_W'(1);
                                if (func_t'(func) == FN_DEL_BACK)
                                    ctrl.pos = count_reg - CNT_W'(1);
                                else if (func_t'(func) == FN_DEL_INDEX)
                                    ctrl.pos = pa_w;
                                else
                                    ctrl.pos = '0;
                            end
                        end
                        FN_SWAP:
                        begin
                            if (count_reg == '0)
                                op_status = ST_EMPTY;
                            else if (pa_w >= count_reg || pb_w >= count_reg)
                                op_status = ST_RANGE;
                            else
                            begin
                                start_swap  = 1'b1;
                                ctrl.rd_pos = pa_w;
                            end
                        end
                        FN_DUMP:
                        begin
                            if (count_reg == '0)
                                op_status = ST_EMPTY;
                            else
                                start_dump = 1'b1;
                        end
                        default:
                        begin
                            op_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SWAP:
            begin
                ctrl.rd_pos = pb_reg;
                if (out_free)
                begin
                    ctrl.op    = CELL_SWAP;
                    ctrl.pos   = pa_reg;
                    ctrl.pos_b = pb_reg;
                    ctrl.a_val = a_val_reg;
                    ctrl.b_val = bus_val;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                    ctrl.op = CELL_ROTATE;
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_w;
            logic signed [VAL_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_val[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_final
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_val[g+1];
            end
            olist_cell #(
                .IDX (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .left_val  (left_w),
                .right_val (right_w),
                .head_val  (cell_val[0]),
                .value     (cell_val[g]),
                .rd_val    (cell_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            a_val_reg     <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            out_value_reg <= '0;
            status_reg    <= ST_OK;
            count_out_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        count_reg <= cnt_next;
                        if (start_swap)
                        begin
                            state_reg <= S_SWAP;
                            pa_reg    <= pa_w;
                            pb_reg    <= pb_w;
                            a_val_reg <= bus_val;
                        end
                        else if (start_dump)
                        begin
                            state_reg    <= S_DUMP;
                            dump_idx_reg <= '0;
                        end
                        else
                        begin
                            out_value_reg <= '0;
                            status_reg    <= op_status;
                            count_out_reg <= cnt_next;
                            last_reg      <= 1'b1;
                        end
                    end
                end
                S_SWAP:
                begin
                    if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        out_value_reg <= '0;
                        status_reg    <= ST_OK;
                        count_out_reg <= count_reg;
                        last_reg      <= 1'b1;
                    end
                end
                S_DUMP:
                begin
                    if (out_free)
                    begin
                        out_value_reg <= cell_val[0];
                        status_reg    <= ST_OK;
                        count_out_reg <= count_reg;
                        last_reg      <= dump_last;
                        dump_idx_reg  <= dump_idx_reg + CNT_W'(1);
                        if (dump_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign out_value     = out_value_reg;
    assign status        = status_reg;
    assign element_count = count_out_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("element count beyond capacity");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> count_out_reg == count_reg)
        else $error("reported count differs from stored count");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(count_reg))
        else $error("count changed without a request");

    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> dump_idx_reg < count_reg)
        else $error("dump ran past the live length");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg == ST_FULL |-> count_reg == CAP_C)
        else $error("full reported on a list with room");
`endif

endmodule

// ----- rtl/core/olist_cell.sv -----
// One storage cell of the ordered list row: holds one word, shifts to or from
// its neighbours, takes part in rotate and swap. Depends on olist_pkg.
module olist_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  olist_pkg::cell_ctrl_t          ctrl,
    input  logic signed [olist_pkg::VAL_W-1:0] left_val,
    input  logic signed [olist_pkg::VAL_W-1:0] right_val,
    input  logic signed [olist_pkg::VAL_W-1:0] head_val,
    output logic signed [olist_pkg::VAL_W-1:0] value,
    output logic signed [olist_pkg::VAL_W-1:0] rd_val
);
    import olist_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                    value_next = ctrl.ins_val;
                else if (MY_IDX > ctrl.pos)
                    value_next = left_val;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.pos)
                    value_next = right_val;
            end
            CELL_ROTATE:
            begin
                // live part moves one step towards the head, head wraps to the tail
                if (MY_IDX == ctrl.count - CNT_W'(1))
                    value_next = head_val;
                else if (MY_IDX < ctrl.count - CNT_W'(1))
                    value_next = right_val;
            end
            CELL_SWAP:
            begin
                if (MY_IDX == ctrl.pos)
                    value_next = ctrl.b_val;
                else if (MY_IDX == ctrl.pos_b)
                    value_next = ctrl.a_val;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value  = value_reg;
    assign rd_val = (MY_IDX == ctrl.rd_pos) ? value_reg : '0;

endmodule

// ----- dv/ordered_list_engine_unit_test.sv -----
// Self-checking testbench for ordered_list_engine_unit: directed and random requests
// against a shadow copy of the list, results checked word by word in order.
// Depends on olist_pkg and the ordered_list_engine_unit RTL.
module ordered_list_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import olist_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 280;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_LEN    = 45;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        status_t                 status;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } list_word_t;

    typedef enum {LOAD_FILL, LOAD_DRAIN, LOAD_MIXED} load_mode_t;

    // shadow of the list contents plus the words still owed by the block
    class list_scoreboard;
        logic signed [VAL_W-1:0] elems [CAPACITY];
        int unsigned             count;
        list_word_t              owed [$];
        int unsigned             mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function void owe(logic signed [VAL_W-1:0] v, status_t st, logic fin);
            list_word_t w;
            w.value  = v;
            w.status = st;
            w.count  = CNT_W'(count);
            w.last   = fin;
            owed.push_back(w);
        endfunction

        function void insert_at(int unsigned p, logic signed [VAL_W-1:0] v);
            int unsigned i;
            for (i = count; i > p; i--)
                elems[i] = elems[i-1];
            elems[p] = v;
            count++;
        endfunction

        function void remove_at(int unsigned p);
            int unsigned i;
            for (i = p; i + 1 < count; i++)
                elems[i] = elems[i+1];
            count--;
        endfunction

        function void note_request(func_t f, logic signed [VAL_W-1:0] v,
                                   logic [POS_W-1:0] pa, logic [POS_W-1:0] pb);
            status_t                 st;
            logic signed [VAL_W-1:0] t;
            int unsigned             i;
            st = ST_OK;
            case (f)
                FN_ADD_FRONT, FN_ADD_BACK, FN_ADD_AFTER:
                begin
                    // full check wins over the position check
                    if (count >= CAPACITY)
                        st = ST_FULL;
                    else if (f == FN_ADD_FRONT)
                        insert_at(0, v);
                    else if (f == FN_ADD_BACK)
                        insert_at(count, v);
                    else if (pa >= count)
                        st = ST_RANGE;
                    else if (pa == 0)
                        insert_at(0, v);
                    else
                        insert_at(pa + 1, v);
                end
                FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_INDEX:
                begin
                    if (count == 0)
                        st = ST_EMPTY;
                    else if (f == FN_DEL_FRONT)
                        remove_at(0);
                    else if (f == FN_DEL_BACK)
                        remove_at(count - 1);
                    else if (pa >= count)
                        st = ST_RANGE;
                    else
                        remove_at(pa);
                end
                FN_SWAP:
                begin
                    if (count == 0)
                        st = ST_EMPTY;
                    else if (pa >= count || pb >= count)
                        st = ST_RANGE;
                    else if (pa != pb)
                    begin
                        t         = elems[pa];
                        elems[pa] = elems[pb];
                        elems[pb] = t;
                    end
                end
                default:
                begin
                    if (count == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        for (i = 0; i < count; i++)
                            owe(elems[i], ST_OK, i + 1 == count);
                        return;
                    end
                end
            endcase
            owe('0, st, 1'b1);
        endfunction

        function void check_result(logic signed [VAL_W-1:0] v, logic [1:0] st,
                                   logic [CNT_W-1:0] cnt, logic fin);
            list_word_t w;
            if (owed.size() == 0)
            begin
                $error("unexpected result word: out_value %0d status %0d count %0d",
                       v, st, cnt);
                mismatches++;
                return;
            end
            w = owed.pop_front();
            if (v !== w.value)
            begin
                $error("out_value: expected %0d, got %0d", w.value, v);
                mismatches++;
            end
            if (st !== w.status)
            begin
                $error("status: expected %0d, got %0d", w.status, st);
                mismatches++;
            end
            if (cnt !== w.count)
            begin
                $error("element_count: expected %0d, got %0d", w.count, cnt);
                mismatches++;
            end
            if (fin !== w.last)
            begin
                $error("last: expected %0d, got %0d", w.last, fin);
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_ready;
    logic [2:0]              func;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position_a;
    logic [POS_W-1:0]        position_b;
    logic                    rsp_valid;
    logic                    rsp_ready;
    logic signed [VAL_W-1:0] out_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        element_count;
    logic                    last;

    logic                    steady;    // no idling on either side while set

    list_scoreboard shadow = new();

    ordered_list_engine_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .func         (func),
        .item_value   (item_value),
        .position_a   (position_a),
        .position_b   (position_b),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .out_value    (out_value),
        .status       (status),
        .element_count(element_count),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready <= steady || ($urandom_range(0, 99) >= 17);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            shadow.check_result(out_value, status, element_count, last);
    end

    // ends the run if no word moves on either side for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(func_t f, logic signed [VAL_W-1:0] v,
                                logic [POS_W-1:0] pa, logic [POS_W-1:0] pb);
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        func       <= f;
        item_value <= v;
        position_a <= pa;
        position_b <= pb;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.note_request(f, v, pa, pb);
        @(negedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // mostly a live position, sometimes anything the field can hold
    function automatic logic [POS_W-1:0] pick_pos();
        if (shadow.count != 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, shadow.count - 1));
        return POS_W'($urandom_range(0, 63));
    endfunction

    task automatic send_random(load_mode_t mode);
        int unsigned add_cut;
        int unsigned del_cut;
        int unsigned swap_cut;
        int unsigned r;
        func_t       f;
        case (mode)
            LOAD_FILL:
            begin
                add_cut = 78; del_cut = 88; swap_cut = 95;
            end
            LOAD_DRAIN:
            begin
                add_cut = 12; del_cut = 82; swap_cut = 94;
            end
            default:
            begin
                add_cut = 40; del_cut = 76; swap_cut = 93;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < add_cut)
            f = func_t'($urandom_range(FN_ADD_FRONT, FN_ADD_AFTER));
        else if (r < del_cut)
            f = func_t'($urandom_range(FN_DEL_FRONT, FN_DEL_INDEX));
        else if (r < swap_cut)
            f = FN_SWAP;
        else
            f = FN_DUMP;
        send_request(f, pick_value(), pick_pos(), pick_pos());
    endtask

    initial
    begin
        int n;
        rst_n      = 1'b0;
        steady     = 1'b0;
        req_valid  = 1'b0;
        func       = FN_DUMP;
        item_value = '0;
        position_a = '0;
        position_b = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list corner cases
        send_request(FN_DUMP, '0, '0, '0);
        send_request(FN_DEL_FRONT, '0, '0, '0);
        send_request(FN_DEL_BACK, '0, '0, '0);
        send_request(FN_DEL_INDEX, '0, '0, '0);
        send_request(FN_SWAP, '0, '0, '0);
        send_request(FN_ADD_AFTER, 32'sd7, '0, '0);
        // value extremes, add-after at front, middle and tail
        send_request(FN_ADD_FRONT, 32'sh7fffffff, 6'd63, 6'd63);
        send_request(FN_ADD_BACK, 32'sh80000000, '0, '0);
        send_request(FN_ADD_FRONT, -32'sd1, '0, '0);
        send_request(FN_ADD_BACK, '0, '0, '0);
        send_request(FN_ADD_AFTER, 32'sh55555555, '0, '0);
        send_request(FN_ADD_AFTER, 32'shaaaaaaaa, 6'd1, '0);
        send_request(FN_ADD_AFTER, 32'sd123, POS_W'(shadow.count - 1), '0);
        send_request(FN_ADD_AFTER, 32'sd9, POS_W'(shadow.count), '0);
        send_request(FN_ADD_AFTER, 32'sd9, 6'd63, '0);
        send_request(FN_DUMP, '0, '0, '0);
        // swaps: equal, ends, out of range either side
        send_request(FN_SWAP, '0, 6'd1, 6'd1);
        send_request(FN_SWAP, '0, '0, POS_W'(shadow.count - 1));
        send_request(FN_SWAP, '0, '0, 6'd63);
        send_request(FN_SWAP, '0, 6'd63, '0);
        send_request(FN_DEL_INDEX, '0, 6'd63, '0);
        send_request(FN_DEL_INDEX, '0, POS_W'(shadow.count), '0);
        send_request(FN_DEL_INDEX, '0, 6'd2, '0);
        send_request(FN_DEL_FRONT, '0, '0, '0);
        send_request(FN_DEL_BACK, '0, '0, '0);
        send_request(FN_DUMP, '0, '0, '0);

        // phases push the list to full and back to empty
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 120 && n < 180);
            send_random(load_mode_t'((n / PHASE_LEN) % 3));
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        while (shadow.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
